FILE: design/csc_pkg.sv
// Shared types and constants for the circle / segment crossing pipeline.
package csc_pkg;

    localparam int COORD_WIDTH = 32;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord                 start_x;
        t_coord                 start_y;
        t_coord                 dir_x;
        t_coord                 dir_y;
        t_coord                 centre_x;
        t_coord                 centre_y;
        logic [COORD_WIDTH-2:0] radius;
    } t_csc_in;

    typedef struct packed {
        logic   crossing_found;
        t_coord crossing_param;
        logic   param_saturated;
    } t_csc_out;

endpackage

FILE: design/csc_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a tag carried alongside.
module csc_isqrt #(
    parameter int RW = 63,
    parameter int TW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [TW-1:0]   i_tag,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [TW-1:0]   o_tag
);
    logic            w_vld  [0:RW];
    logic [2*RW-1:0] w_rad  [0:RW];
    logic [RW+1:0]   w_rem  [0:RW];
    logic [RW-1:0]   w_root [0:RW];
    logic [TW-1:0]   w_tag  [0:RW];

    assign w_vld[0]  = i_valid;
    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_tag[0]  = i_tag;

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic            r_vld;
        logic [2*RW-1:0] r_rad;
        logic [RW+1:0]   r_rem;
        logic [RW-1:0]   r_root;
        logic [TW-1:0]   r_tag;
        logic [RW+1:0]   n_rem_sh;
        logic [RW+1:0]   n_trial;
        logic            n_take;

        always_comb begin
            n_rem_sh = {w_rem[g][RW-1:0], w_rad[g][2*RW-1:2*RW-2]};
            n_trial  = {w_root[g], 2'b01};
            n_take   = (n_rem_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad  <= {w_rad[g][2*RW-3:0], 2'b00};
            r_rem  <= n_take ? (n_rem_sh - n_trial) : n_rem_sh;
            r_root <= {w_root[g][RW-2:0], n_take};
            r_tag  <= w_tag[g];
        end

        assign w_vld[g+1]  = r_vld;
        assign w_rad[g+1]  = r_rad;
        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
        assign w_tag[g+1]  = r_tag;
    end

    assign o_valid = w_vld[RW];
    assign o_root  = w_root[RW];
    assign o_tag   = w_tag[RW];
endmodule

FILE: design/csc_udiv.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with a tag carried alongside.
module csc_udiv #(
    parameter int NW = 86,
    parameter int DW = 65,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quot,
    output logic [TW-1:0] o_tag
);
    logic          w_vld [0:NW];
    logic [NW-1:0] w_num [0:NW];
    logic [DW-1:0] w_den [0:NW];
    logic [DW-1:0] w_rem [0:NW];
    logic [NW-1:0] w_quo [0:NW];
    logic [TW-1:0] w_tag [0:NW];

    assign w_vld[0] = i_valid;
    assign w_num[0] = i_num;
    assign w_den[0] = i_den;
    assign w_rem[0] = '0;
    assign w_quo[0] = '0;
    assign w_tag[0] = i_tag;

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic          r_vld;
        logic [NW-1:0] r_num;
        logic [DW-1:0] r_den;
        logic [DW-1:0] r_rem;
        logic [NW-1:0] r_quo;
        logic [TW-1:0] r_tag;
        logic [DW:0]   n_rem_sh;
        logic [DW:0]   n_diff;
        logic          n_take;

        always_comb begin
            n_rem_sh = {w_rem[g], w_num[g][NW-1]};
            n_diff   = n_rem_sh - {1'b0, w_den[g]};
            n_take   = (n_rem_sh >= {1'b0, w_den[g]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_num <= {w_num[g][NW-2:0], 1'b0};
            r_den <= w_den[g];
            r_rem <= n_take ? n_diff[DW-1:0] : n_rem_sh[DW-1:0];
            r_quo <= {w_quo[g][NW-2:0], n_take};
            r_tag <= w_tag[g];
        end

        assign w_vld[g+1] = r_vld;
        assign w_num[g+1] = r_num;
        assign w_den[g+1] = r_den;
        assign w_rem[g+1] = r_rem;
        assign w_quo[g+1] = r_quo;
        assign w_tag[g+1] = r_tag;
    end

    assign o_valid = w_vld[NW];
    assign o_quot  = w_quo[NW];
    assign o_tag   = w_tag[NW];
endmodule

FILE: design/circle_segment_crossing.sv
// Circle / segment crossing: fixed-point line parameter of the crossing nearest t = 0.5.
// A beat is taken on any cycle with start high; busy stays low, so one item enters per cycle.
// Each result appears on o_result for one cycle with o_done high. Its path from the start beat
// runs through stages 1 to 7, the square root pipe (one root bit per stage), stages 8 to 10,
// the divider pipe (one quotient bit per stage) and the output register. The receiver cannot
// stall the block.
module circle_segment_crossing #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  csc_pkg::t_csc_in  i_data,
    output logic              o_done,
    output csc_pkg::t_csc_out o_result
);
    import csc_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int SW  = 2*W - 1;
    localparam int NSW = 2*W + 4;
    localparam int NW  = 2*W + F + 6;
    localparam int TW1 = 4*W + 4;

    assign busy = 1'b0;

    // stage 1
    logic                r1_vld, r1_zero;
    logic signed [W:0]   r1_dx, r1_dy;
    logic signed [W-1:0] r1_ux, r1_uy;
    logic [W-2:0]        r1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx   <= (W+1)'(i_data.start_x) - (W+1)'(i_data.centre_x);
        r1_dy   <= (W+1)'(i_data.start_y) - (W+1)'(i_data.centre_y);
        r1_ux   <= i_data.dir_x;
        r1_uy   <= i_data.dir_y;
        r1_r    <= i_data.radius;
        r1_zero <= (i_data.dir_x == '0) && (i_data.dir_y == '0);
    end

    // stage 2
    logic                 r2_vld, r2_zero;
    logic signed [2*W:0]  r2_dxux, r2_dyuy, r2_dxuy, r2_dyux;
    logic signed [2*W-1:0] r2_uxux, r2_uyuy;
    logic [2*W-3:0]       r2_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_dxux <= r1_dx * r1_ux;
        r2_dyuy <= r1_dy * r1_uy;
        r2_dxuy <= r1_dx * r1_uy;
        r2_dyux <= r1_dy * r1_ux;
        r2_uxux <= r1_ux * r1_ux;
        r2_uyuy <= r1_uy * r1_uy;
        r2_rr   <= r1_r * r1_r;
        r2_zero <= r1_zero;
    end

    // stage 3
    logic                  r3_vld, r3_zero;
    logic [2*W-1:0]        r3_d;
    logic signed [2*W+1:0] r3_b, r3_x;
    logic [2*W-3:0]        r3_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_d    <= $unsigned(r2_uxux) + $unsigned(r2_uyuy);
        r3_b    <= (2*W+2)'(r2_dxux) + (2*W+2)'(r2_dyuy);
        r3_x    <= (2*W+2)'(r2_dxuy) - (2*W+2)'(r2_dyux);
        r3_rr   <= r2_rr;
        r3_zero <= r2_zero;
    end

    // stage 4
    logic                  r4_vld, r4_zero;
    logic [2*W-1:0]        r4_d;
    logic signed [2*W+1:0] r4_b;
    logic [2*W:0]          r4_ax;
    logic [2*W-3:0]        r4_rr;
    logic signed [2*W+1:0] n_negx;

    assign n_negx = -r3_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_ax   <= r3_x[2*W+1] ? n_negx[2*W:0] : r3_x[2*W:0];
        r4_d    <= r3_d;
        r4_b    <= r3_b;
        r4_rr   <= r3_rr;
        r4_zero <= r3_zero;
    end

    // stage 5: partial products of r^2 * D and X^2
    logic                  r5_vld, r5_zero;
    logic [2*W-1:0]        r5_d;
    logic signed [2*W+1:0] r5_b;
    logic [2*W-2:0]        r5_ll, r5_lh, r5_hl, r5_hh;
    logic [2*W+1:0]        r5_al2;
    logic [2*W:0]          r5_alah;
    logic [2*W-1:0]        r5_ah2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_ll   <= r4_rr[W-2:0] * r4_d[W-1:0];
        r5_lh   <= r4_rr[W-2:0] * r4_d[2*W-1:W];
        r5_hl   <= r4_rr[2*W-3:W-1] * r4_d[W-1:0];
        r5_hh   <= r4_rr[2*W-3:W-1] * r4_d[2*W-1:W];
        r5_al2  <= r4_ax[W:0] * r4_ax[W:0];
        r5_alah <= r4_ax[W:0] * r4_ax[2*W:W+1];
        r5_ah2  <= r4_ax[2*W:W+1] * r4_ax[2*W:W+1];
        r5_d    <= r4_d;
        r5_b    <= r4_b;
        r5_zero <= r4_zero;
    end

    // stage 6
    logic                  r6_vld, r6_zero;
    logic [2*W-1:0]        r6_d;
    logic signed [2*W+1:0] r6_b;
    logic [4*W-3:0]        r6_rd;
    logic [4*W:0]          r6_x2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_rd   <= ((4*W-2)'(r5_hh) << (2*W-1)) + ((4*W-2)'(r5_lh) << W)
                 + ((4*W-2)'(r5_hl) << (W-1)) + (4*W-2)'(r5_ll);
        r6_x2   <= ((4*W+1)'(r5_ah2) << (2*W+2)) + ((4*W+1)'(r5_alah) << (W+2))
                 + (4*W+1)'(r5_al2);
        r6_d    <= r5_d;
        r6_b    <= r5_b;
        r6_zero <= r5_zero;
    end

    // stage 7: discriminant
    logic                  r7_vld, r7_none, r7_nz;
    logic [2*W-1:0]        r7_d;
    logic signed [2*W+1:0] r7_b;
    logic [2*SW-1:0]       r7_rad;
    logic signed [4*W+1:0] n_disc;

    assign n_disc = $signed((4*W+2)'(r6_rd)) - $signed((4*W+2)'(r6_x2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_rad  <= n_disc[4*W+1] ? '0 : n_disc[2*SW-1:0];
        r7_nz   <= (n_disc != '0);
        r7_none <= r6_zero | n_disc[4*W+1];
        r7_d    <= r6_d;
        r7_b    <= r6_b;
    end

    logic            s_vld;
    logic [SW-1:0]   s_root;
    logic [TW1-1:0]  s_tag;

    csc_isqrt #(
        .RW (SW),
        .TW (TW1)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_vld),
        .i_rad   (r7_rad),
        .i_tag   ({r7_b, r7_d, r7_nz, r7_none}),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_tag   (s_tag)
    );

    // stage 8: pick the root
    logic                  r8_vld, r8_none;
    logic signed [NSW-1:0] r8_n;
    logic [2*W-1:0]        r8_d;
    logic signed [2*W+1:0] s_b;
    logic [2*W-1:0]        s_d;
    logic signed [NSW-1:0] n_n0, n_s, n_cmp;
    logic                  n_lower;

    always_comb begin
        s_b     = $signed(s_tag[TW1-1:2*W+2]);
        s_d     = s_tag[2*W+1:2];
        n_n0    = -(NSW'(s_b));
        n_s     = $signed(NSW'(s_root));
        n_cmp   = (n_n0 <<< 1) - $signed(NSW'(s_d));
        n_lower = s_tag[1] && !n_cmp[NSW-1] && (n_cmp != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_n    <= n_lower ? (n_n0 - n_s) : (n_n0 + n_s);
        r8_d    <= s_d;
        r8_none <= s_tag[0];
    end

    // stage 9: numerator
    logic                 r9_vld, r9_none;
    logic signed [NW-1:0] r9_num;
    logic [2*W-1:0]       r9_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r9_num  <= (NW'(r8_n) <<< (F+1)) + $signed(NW'(r8_d));
        r9_d    <= r8_d;
        r9_none <= r8_none;
    end

    // stage 10: magnitude with ceiling bias for negative numerators
    logic           r10_vld, r10_none, r10_neg;
    logic [NW-1:0]  r10_mag;
    logic [2*W:0]   r10_den;
    logic [NW-1:0]  n_negnum;

    assign n_negnum = $unsigned(-r9_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else begin
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r10_mag  <= r9_num[NW-1] ? (n_negnum + NW'({r9_d, 1'b0}) - NW'(1))
                                 : $unsigned(r9_num);
        r10_den  <= {r9_d, 1'b0};
        r10_neg  <= r9_num[NW-1];
        r10_none <= r9_none;
    end

    logic          q_vld;
    logic [NW-1:0] q_quot;
    logic [1:0]    q_tag;

    csc_udiv #(
        .NW (NW),
        .DW (2*W+1),
        .TW (2)
    ) u_udiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r10_vld),
        .i_num   (r10_mag),
        .i_den   (r10_den),
        .i_tag   ({r10_neg, r10_none}),
        .o_valid (q_vld),
        .o_quot  (q_quot),
        .o_tag   (q_tag)
    );

    // output stage: sign, clamp
    logic                r_done;
    t_csc_out            r_result;
    logic signed [NW:0]  n_qs, n_q;
    logic                n_hi, n_lo;
    t_csc_out            n_result;

    always_comb begin
        n_qs = $signed({1'b0, q_quot});
        n_q  = q_tag[1] ? -n_qs : n_qs;
        n_hi = !n_q[NW] && (|n_q[NW-1:W-1]);
        n_lo = n_q[NW] && !(&n_q[NW-1:W-1]);
        n_result.crossing_found  = 1'b1;
        n_result.param_saturated = n_hi | n_lo;
        n_result.crossing_param  = n_q[W-1:0];
        if (n_hi) begin
            n_result.crossing_param = {1'b0, {(W-1){1'b1}}};
        end else if (n_lo) begin
            n_result.crossing_param = {1'b1, {(W-1){1'b0}}};
        end
        if (q_tag[0]) begin
            n_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_sat_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.param_saturated |-> o_result.crossing_found)
        else $error("saturation flagged without a crossing");
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.crossing_found |-> o_result.crossing_param == '0)
        else $error("no crossing but nonzero parameter");
    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.param_saturated |->
        (o_result.crossing_param == {1'b0, {(W-1){1'b1}}}) ||
        (o_result.crossing_param == {1'b1, {(W-1){1'b0}}}))
        else $error("saturated parameter not at a range limit");
`endif
endmodule

FILE: tb/tb_circle_segment_crossing.sv
// Self-checking testbench for circle_segment_crossing: directed and random segment/circle beats.
module tb_circle_segment_crossing;
    timeunit 1ns;
    timeprecision 1ps;
    import csc_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 200;
    localparam logic signed [255:0] PARAM_MAX = 256'sd2147483647;
    localparam logic signed [255:0] PARAM_MIN = -256'sd2147483648;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_csc_in  i_data = '0;
    logic     o_done;
    t_csc_out o_result;

    t_csc_out crossings_pending[$];
    bit       failed = 1'b0;
    bit       gaps_on = 1'b1;

    circle_segment_crossing #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_data(i_data), .o_done(o_done), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_csc_out crossing_of(t_csc_in b);
        logic signed [255:0] dx, dy, wx, wy, r, dd, bb, xx, disc, s, cand, n, num, den, q;
        t_csc_out res;
        res = '0;
        if (b.dir_x == 0 && b.dir_y == 0) return res;
        dx = 256'(b.start_x) - 256'(b.centre_x);
        dy = 256'(b.start_y) - 256'(b.centre_y);
        wx = 256'(b.dir_x);
        wy = 256'(b.dir_y);
        r = {225'b0, b.radius};
        dd = wx * wx + wy * wy;
        bb = dx * wx + dy * wy;
        xx = dx * wy - dy * wx;
        disc = r * r * dd - xx * xx;
        if (disc < 0) return res;
        s = '0;
        for (int k = 70; k >= 0; k--) begin
            cand = s | (256'sd1 <<< k);
            if (cand * cand <= disc) s = cand;
        end
        n = -bb;
        if (disc != 0 && (n * 2 - dd) > 0) n = n - s;
        else n = n + s;
        num = (n <<< (FRAC + 1)) + dd;
        den = dd * 2;
        q = num / den;
        if (num < 0 && q * den != num) q = q - 1;
        res.crossing_found = 1'b1;
        if (q > PARAM_MAX) begin
            q = PARAM_MAX;
            res.param_saturated = 1'b1;
        end else if (q < PARAM_MIN) begin
            q = PARAM_MIN;
            res.param_saturated = 1'b1;
        end
        res.crossing_param = q[31:0];
        return res;
    endfunction

    task automatic send_beat(t_csc_in b);
        start <= 1'b1;
        i_data <= b;
        do @(posedge i_clk); while (busy);
        crossings_pending.push_back(crossing_of(b));
        if (gaps_on) begin
            while ($urandom_range(99) < 34) begin
                start <= 1'b0;
                i_data <= '0;
                @(posedge i_clk);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_csc_out exp_r;
        if (i_rst_n && o_done) begin
            if (crossings_pending.size() == 0) begin
                $error("result with no expectation waiting");
                failed = 1'b1;
            end else begin
                exp_r = crossings_pending.pop_front();
                if (o_result.crossing_found !== exp_r.crossing_found) begin
                    $error("crossing_found exp %0d got %0d", exp_r.crossing_found,
                           o_result.crossing_found);
                    failed = 1'b1;
                end
                if (o_result.crossing_param !== exp_r.crossing_param) begin
                    $error("crossing_param exp %0d got %0d", exp_r.crossing_param,
                           o_result.crossing_param);
                    failed = 1'b1;
                end
                if (o_result.param_saturated !== exp_r.param_saturated) begin
                    $error("param_saturated exp %0d got %0d", exp_r.param_saturated,
                           o_result.param_saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic t_csc_in beat_of(int sx, int sy, int ux, int uy, int cx, int cy,
                                        logic [30:0] rad);
        t_csc_in b;
        b.start_x = sx; b.start_y = sy; b.dir_x = ux; b.dir_y = uy;
        b.centre_x = cx; b.centre_y = cy; b.radius = rad;
        return b;
    endfunction

    task automatic test_directed();
        localparam int ONE = 1 << FRAC;
        send_beat(beat_of(0, 0, 0, 0, 0, 0, 31'(ONE)));
        send_beat(beat_of(0, 0, ONE, 0, 0, 5 * ONE, 31'(ONE)));
        send_beat(beat_of(0, ONE, ONE, 0, 0, 0, 31'(ONE)));
        send_beat(beat_of(-ONE, 0, 2 * ONE, 0, 0, 0, 31'(ONE)));
        send_beat(beat_of(-2 * ONE, 0, 4 * ONE, 0, 0, 0, 31'(ONE / 2)));
        send_beat(beat_of(0, 0, 1, 0, 32'sh7fff_0000, 0, 31'(ONE)));
        send_beat(beat_of(0, 0, 1, 0, 32'sh8000_0000, 0, 31'(ONE)));
        send_beat(beat_of(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                          32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff));
        send_beat(beat_of(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff));
        send_beat(beat_of(-1, -1, -1, -1, -1, -1, '1));
        send_beat(beat_of(0, 0, 0, 1, 0, 0, '0));
        send_beat(beat_of(ONE, ONE, -ONE, -ONE, 0, 0, '0));
        send_beat(beat_of(0, 0, ONE, ONE, 0, 0, '1));
    endtask

    task automatic test_random(int count);
        t_csc_in b;
        for (int i = 0; i < count; i++) begin
            gaps_on = !(i >= count / 3 && i < count / 2);
            b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
            if ($urandom_range(99) < 70) begin
                b.radius = 31'($urandom_range(1 << 22));
                b.start_x = b.centre_x + $signed($urandom_range(1 << 23)) - (1 << 22);
                b.start_y = b.centre_y + $signed($urandom_range(1 << 23)) - (1 << 22);
                b.dir_x = $signed($urandom_range(1 << 21)) - (1 << 20);
                b.dir_y = $signed($urandom_range(1 << 21)) - (1 << 20);
            end
            send_beat(b);
        end
        start <= 1'b0;
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600);
        while (crossings_pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (!failed) $display("tb_circle_segment_crossing passed");
        else $display("tb_circle_segment_crossing failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_circle_segment_crossing failed");
        $finish;
    end
endmodule
